FILE: rtl/mtsfo_pkg.sv
`default_nettype none

package mtsfo_pkg;

    localparam int unsigned WordWidth = 32;
    localparam int unsigned ByteWidth = 8;
    localparam int unsigned AddrWidth = 3;

    // Seeding recurrence and twist/temper constants
    localparam logic [WordWidth-1:0] SeedMult  = 32'd1812433253;
    localparam logic [WordWidth-1:0] UpperMask = 32'h8000_0000;
    localparam logic [WordWidth-1:0] LowerMask = 32'h7fff_ffff;
    localparam logic [WordWidth-1:0] MatrixA   = 32'h9908_b0df;
    localparam logic [WordWidth-1:0] TemperB   = 32'h9d2c_5680;
    localparam logic [WordWidth-1:0] TemperC   = 32'hefc6_0000;
    localparam int unsigned          ShiftM    = 397;
    localparam int unsigned          StepWidth = $clog2(ShiftM + 1);

    localparam logic [ByteWidth-1:0] FpFirstReset  = 8'h71;
    localparam logic [ByteWidth-1:0] FpSecondReset = 8'h23;

    // Register indexes (byte address bit 2)
    localparam logic RegFpFirst  = 1'b0;
    localparam logic RegFpSecond = 1'b1;

    // Word carried down the chain of seeding cells
    typedef struct packed {
        logic [WordWidth-1:0] cur;
        logic [WordWidth-1:0] w1;
        logic [WordWidth-1:0] seed;
    } mtsfo_word_t;

    // Fingerprint bytes from the register file
    typedef struct packed {
        logic [ByteWidth-1:0] first;
        logic [ByteWidth-1:0] second;
    } mtsfo_fp_t;

endpackage

`default_nettype wire

FILE: rtl/mtsfo_if.sv
`default_nettype none

interface mtsfo_seed_if;
    logic                              valid;
    logic                              ready;
    logic [mtsfo_pkg::WordWidth-1:0]   seed;

    modport source (output valid, output seed, input ready);
    modport sink   (input valid, input seed, output ready);
endinterface

interface mtsfo_result_if;
    logic                              valid;
    logic                              ready;
    logic [mtsfo_pkg::WordWidth-1:0]   first_word;
    logic                              match_big_endian;
    logic                              match_little_endian;
    logic [mtsfo_pkg::WordWidth-1:0]   seed_echo;

    modport source (output valid, output first_word, output match_big_endian,
                    output match_little_endian, output seed_echo, input ready);
    modport sink   (input valid, input first_word, input match_big_endian,
                    input match_little_endian, input seed_echo, output ready);
endinterface

`default_nettype wire

FILE: rtl/mtsfo_cell.sv
`default_nettype none

module mtsfo_cell (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             advance,
    input  wire logic [mtsfo_pkg::StepWidth-1:0]  step,
    input  wire logic                             in_valid,
    input  wire mtsfo_pkg::mtsfo_word_t           in_data,
    output logic                                  out_valid,
    output mtsfo_pkg::mtsfo_word_t                out_data
);
    import mtsfo_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    mtsfo_word_t           data_reg;
    mtsfo_word_t           data_next;
    logic [WordWidth-1:0]  mixed;
    logic [WordWidth-1:0]  product;
    logic [WordWidth-1:0]  word_k;

    // One step of the seeding recurrence: one multiplier, one add
    always_comb
    begin
        mixed      = in_data.cur ^ (in_data.cur >> 30);
        product    = SeedMult * mixed;
        word_k     = product + {{(WordWidth-StepWidth){1'b0}}, step};
        data_next      = in_data;
        data_next.cur  = word_k;
        if (step == StepWidth'(1))
        begin
            data_next.w1 = word_k;
        end
        valid_next = advance ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

FILE: rtl/mtsfo_finish.sv
`default_nettype none

module mtsfo_finish (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     advance,
    input  wire logic                     in_valid,
    input  wire mtsfo_pkg::mtsfo_word_t   in_data,
    input  wire mtsfo_pkg::mtsfo_fp_t     fp,
    mtsfo_result_if.source                result_ch
);
    import mtsfo_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    logic [WordWidth-1:0]  word_reg;
    logic [WordWidth-1:0]  seed_reg;
    logic                  big_reg;
    logic                  little_reg;
    logic [WordWidth-1:0]  y;
    logic [WordWidth-1:0]  twisted;
    logic [WordWidth-1:0]  t0;
    logic [WordWidth-1:0]  t1;
    logic [WordWidth-1:0]  t2;
    logic [WordWidth-1:0]  word;
    logic                  big_next;
    logic                  little_next;

    // Twist slot 0, temper, compare against the fingerprint
    always_comb
    begin
        y       = (in_data.seed & UpperMask) | (in_data.w1 & LowerMask);
        twisted = in_data.cur ^ (y >> 1) ^ (y[0] ? MatrixA : '0);
        t0      = twisted ^ (twisted >> 11);
        t1      = t0 ^ ((t0 << 7) & TemperB);
        t2      = t1 ^ ((t1 << 15) & TemperC);
        word    = t2 ^ (t2 >> 18);
        big_next    = (word[31:24] == fp.first) && (word[23:16] == fp.second);
        little_next = (word[7:0] == fp.first) && (word[15:8] == fp.second);
        valid_next  = advance ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            word_reg   <= word;
            seed_reg   <= in_data.seed;
            big_reg    <= big_next;
            little_reg <= little_next;
        end
    end

    assign result_ch.valid               = valid_reg;
    assign result_ch.first_word          = word_reg;
    assign result_ch.seed_echo           = seed_reg;
    assign result_ch.match_big_endian    = big_reg;
    assign result_ch.match_little_endian = little_reg;

endmodule

`default_nettype wire

FILE: rtl/mtsfo_cfg.sv
`default_nettype none

module mtsfo_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [mtsfo_pkg::AddrWidth-1:0]  paddr,
    input  wire logic [mtsfo_pkg::WordWidth-1:0]  pwdata,
    output logic      [mtsfo_pkg::WordWidth-1:0]  prdata,
    output logic                                  pready,
    output mtsfo_pkg::mtsfo_fp_t                  fp
);
    import mtsfo_pkg::*;

    logic [ByteWidth-1:0]  fp_first_reg;
    logic [ByteWidth-1:0]  fp_second_reg;
    logic [ByteWidth-1:0]  fp_first_next;
    logic [ByteWidth-1:0]  fp_second_next;
    logic                  wr_en;
    logic                  reg_idx;

    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        fp_first_next  = fp_first_reg;
        fp_second_next = fp_second_reg;
        prdata         = '0;
        unique case (reg_idx)
            RegFpFirst:
            begin
                prdata = {{(WordWidth-ByteWidth){1'b0}}, fp_first_reg};
                if (wr_en)
                begin
                    fp_first_next = pwdata[ByteWidth-1:0];
                end
            end
            RegFpSecond:
            begin
                prdata = {{(WordWidth-ByteWidth){1'b0}}, fp_second_reg};
                if (wr_en)
                begin
                    fp_second_next = pwdata[ByteWidth-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fp_first_reg  <= FpFirstReset;
            fp_second_reg <= FpSecondReset;
        end
        else
        begin
            fp_first_reg  <= fp_first_next;
            fp_second_reg <= fp_second_next;
        end
    end

    assign fp.first  = fp_first_reg;
    assign fp.second = fp_second_reg;

endmodule

`default_nettype wire

FILE: rtl/mt19937_seed_first_output.sv
// First tempered output of a freshly seeded 32-bit Mersenne Twister.
// seed_ch (valid/ready sink) takes one 32-bit seed per item. result_ch
// (valid/ready source) returns the first output word, the seed it came
// from and two fingerprint match flags: big-endian on bits 31:16 and
// little-endian on bits 7:0 then 15:8.
// The seeding recurrence runs down a row of 397 identical cells, one
// multiply-add each, followed by one twist/temper/compare stage with the
// output register. An item accepted on seed_ch passes through every cell
// register and then the output register before it shows up on result_ch.
// One item enters per cycle while result_ch is not stalled. When the
// receiver stalls with a result held, the whole chain freezes and
// seed_ch.ready drops until that result is taken.
// Reset (rst_n, asynchronous, active low) empties the chain and loads the
// fingerprint registers with 0x71 and 0x23. Registers sit on an APB port
// at byte addresses 0 (first byte) and 4 (second byte).
`default_nettype none

module mt19937_seed_first_output (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    mtsfo_seed_if.sink                            seed_ch,
    mtsfo_result_if.source                        result_ch,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [mtsfo_pkg::AddrWidth-1:0]  paddr,
    input  wire logic [mtsfo_pkg::WordWidth-1:0]  pwdata,
    output logic      [mtsfo_pkg::WordWidth-1:0]  prdata,
    output logic                                  pready
);
    import mtsfo_pkg::*;

    // Advance the whole chain whenever the output register is free or
    // being drained this cycle; otherwise hold everything in place.
    logic               advance;
    logic [ShiftM:0]    chain_valid;
    mtsfo_word_t        chain_data [0:ShiftM];
    mtsfo_fp_t          fp;

    assign advance       = !result_ch.valid || result_ch.ready;
    assign seed_ch.ready = advance;

    // Head of the chain: word 0 is the seed itself
    assign chain_valid[0]     = seed_ch.valid;
    assign chain_data[0].cur  = seed_ch.seed;
    assign chain_data[0].w1   = '0;
    assign chain_data[0].seed = seed_ch.seed;

    // Cell k produces word k of the seeded state; cell 1 also keeps word 1
    for (genvar g = 1; g <= ShiftM; g++)
    begin : g_cell
        mtsfo_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .step      (StepWidth'(g)),
            .in_valid  (chain_valid[g-1]),
            .in_data   (chain_data[g-1]),
            .out_valid (chain_valid[g]),
            .out_data  (chain_data[g])
        );
    end

    // Twist slot 0 with words 0, 1 and 397, temper, compare, register
    mtsfo_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (chain_valid[ShiftM]),
        .in_data   (chain_data[ShiftM]),
        .fp        (fp),
        .result_ch (result_ch)
    );

    mtsfo_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .fp      (fp)
    );

`ifndef SYNTHESIS
    // A held result must block new seeds
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (result_ch.valid && !result_ch.ready) |-> !seed_ch.ready)
        else $error("seed accepted while result stalled");

    // A frozen chain keeps every stage's occupancy
    a_chain_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(chain_valid[ShiftM:1]))
        else $error("chain moved while stalled");

    // A new result only comes from a filled last cell
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_ch.valid) |-> $past(chain_valid[ShiftM]))
        else $error("result appeared without a finished item");
`endif

endmodule

`default_nettype wire
